[sv/bcu_pkg.sv]
// Shared widths and status codes of the binomial coefficient unit.
`timescale 1ns / 1ps
package bcu_pkg;
  localparam int FIELD_W = 6;    // signed operand width
  localparam int FACT_W  = 5;    // one factor, at most MAX_N
  localparam int MCNT_W  = 4;    // factor count, at most MAX_N / 2
  localparam int NUM_W   = 40;   // numerator product, below 2**40
  localparam int DEN_W   = 22;   // denominator product, at most 10!
  localparam int COEF_W  = 18;   // result width
  localparam int STAT_W  = 2;
  localparam int MAX_N   = 20;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_K_GT_N  = 2'd1;
  localparam logic [STAT_W-1:0] ST_N_RANGE = 2'd2;
endpackage

[sv/bcu_prod.sv]
// Bit-serial shift-and-add builder of the numerator and denominator products.
`timescale 1ns / 1ps
module bcu_prod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcu_pkg::FACT_W-1:0]  n,
  input  logic [bcu_pkg::MCNT_W-1:0]  m,
  output logic                        done,
  output logic [bcu_pkg::NUM_W-1:0]   num,
  output logic [bcu_pkg::DEN_W-1:0]   den
);
  import bcu_pkg::*;

  localparam int BIT_W = $clog2(FACT_W);

  typedef enum logic [1:0] {P_IDLE, P_SETUP, P_SHIFT} pstate_t;

  pstate_t             state;
  logic [NUM_W-1:0]    acc_n, mc_n;
  logic [DEN_W-1:0]    acc_d, mc_d;
  logic [FACT_W-1:0]   mb_n, mb_d;
  logic [FACT_W-1:0]   fac_n, fac_d;
  logic [MCNT_W-1:0]   left;
  logic [BIT_W-1:0]    bit_cnt;

  assign num = acc_n;
  assign den = acc_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        P_IDLE: begin
          if (start) begin
            acc_n <= NUM_W'(1);
            acc_d <= DEN_W'(1);
            fac_n <= n;
            fac_d <= FACT_W'(1);
            left  <= m;
            state <= P_SETUP;
          end
        end
        P_SETUP: begin
          if (left == '0) begin
            done  <= 1'b1;
            state <= P_IDLE;
          end else begin
            // Move the running products into the multiplicand registers.
            mc_n    <= acc_n;
            mc_d    <= acc_d;
            acc_n   <= '0;
            acc_d   <= '0;
            mb_n    <= fac_n;
            mb_d    <= fac_d;
            bit_cnt <= '0;
            state   <= P_SHIFT;
          end
        end
        P_SHIFT: begin
          if (mb_n[0]) acc_n <= acc_n + mc_n;
          if (mb_d[0]) acc_d <= acc_d + mc_d;
          mc_n    <= {mc_n[NUM_W-2:0], 1'b0};
          mc_d    <= {mc_d[DEN_W-2:0], 1'b0};
          mb_n    <= mb_n >> 1;
          mb_d    <= mb_d >> 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_W'(FACT_W - 1)) begin
            fac_n <= fac_n - 1'b1;
            fac_d <= fac_d + 1'b1;
            left  <= left - 1'b1;
            state <= P_SETUP;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  a_done_from_setup: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == P_SETUP)
    else $error("product done without a final setup step");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == P_IDLE && start) |=> state == P_SETUP)
    else $error("product start not taken");
  a_shift_bounded: assert property (@(posedge clk) disable iff (rst)
    state == P_SHIFT |-> bit_cnt < BIT_W'(FACT_W))
    else $error("shift count past factor width");
endmodule

[sv/bcu_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bcu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcu_pkg::NUM_W-1:0]   dividend,
  input  logic [bcu_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [bcu_pkg::COEF_W-1:0]  quotient
);
  import bcu_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            state;
  logic [DEN_W-1:0]   rem, dsr;
  logic [NUM_W-1:0]   quo;
  logic [CNT_W-1:0]   cnt;
  logic [DEN_W:0]     rem_sh, diff;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign diff     = rem_sh - {1'b0, dsr};
  assign quotient = quo[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            rem   <= '0;
            dsr   <= divisor;
            quo   <= dividend;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          // Keep the difference when the trial subtract does not borrow.
          rem <= diff[DEN_W] ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], ~diff[DEN_W]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == D_RUN && state == D_IDLE))
    else $error("divider done outside a run");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == D_RUN && cnt != '0) |-> rem < dsr)
    else $error("partial remainder not reduced");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (state == D_IDLE && start) |=> (state == D_RUN && cnt == '0))
    else $error("divider start not taken");
endmodule

[sv/binomial_coefficient_unit.sv]
// Top level of the binomial coefficient unit: operand check, control and result register.
// Results: an item in error gives its result in the cycle after it is accepted; a valid item
//   runs through the product builder, m = min(k, n-k) <= 10 factors a product, then the divider.
// Handshake: one item at a time; busy stays high until the result strobe for a valid item;
//   an item in error never raises busy. The bit-serial builder and divider set the pace.
// Reset: synchronous, active high; clears control and the result strobe. The receiver
//   cannot stall, so each result is shown on done for exactly one cycle.
`timescale 1ns / 1ps
module binomial_coefficient_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [bcu_pkg::FIELD_W-1:0] n_in,
  input  logic signed [bcu_pkg::FIELD_W-1:0] k_in,
  output logic                               done,
  output logic [bcu_pkg::COEF_W-1:0]         coefficient,
  output logic [bcu_pkg::STAT_W-1:0]         status
);
  import bcu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PROD, S_DIV} state_t;

  state_t              state;
  logic [FIELD_W-1:0]  n_mag, k_mag, n_less_k, m_full;
  logic                accept, k_gt_n, n_big;
  logic                prod_start, prod_done, div_done;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [COEF_W-1:0]   quotient;

  // Take magnitudes; the most negative code becomes 32, which still fits unsigned.
  assign n_mag = n_in[FIELD_W-1] ? (~$unsigned(n_in) + 1'b1) : $unsigned(n_in);
  assign k_mag = k_in[FIELD_W-1] ? (~$unsigned(k_in) + 1'b1) : $unsigned(k_in);

  assign k_gt_n   = k_mag > n_mag;
  assign n_big    = n_mag > FIELD_W'(MAX_N);
  assign n_less_k = n_mag - k_mag;
  // Number of factors in each product: n - max(k, n-k) = min(k, n-k).
  assign m_full   = (n_less_k < k_mag) ? n_less_k : k_mag;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign prod_start = accept && !k_gt_n && !n_big;

  bcu_prod u_prod (
    .clk   (clk),
    .rst   (rst),
    .start (prod_start),
    .n     (n_mag[FACT_W-1:0]),
    .m     (m_full[MCNT_W-1:0]),
    .done  (prod_done),
    .num   (num),
    .den   (den)
  );

  // The products stay put in the builder while the divider loads them.
  bcu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (prod_done),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (k_gt_n) begin
              // The k check comes first, even when n is also out of range.
              done        <= 1'b1;
              status      <= ST_K_GT_N;
              coefficient <= '0;
            end else if (n_big) begin
              done        <= 1'b1;
              status      <= ST_N_RANGE;
              coefficient <= '0;
            end else begin
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          if (prod_done) state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            status      <= ST_OK;
            coefficient <= quotient;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> coefficient == '0)
    else $error("error item with nonzero coefficient");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_K_GT_N || status == ST_N_RANGE))
    else $error("undefined status code");
  a_prod_in_state: assert property (@(posedge clk) disable iff (rst)
    prod_done |-> state == S_PROD)
    else $error("products finished outside the product phase");
  a_div_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> (done && status == ST_OK && !busy))
    else $error("quotient not delivered");
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    prod_start |=> busy && !done)
    else $error("valid item did not hold the unit busy");
endmodule
